>>> rtl/hslc_pkg.sv
// Shared types and constants for the HSL to RGB converter.
// No dependencies; imported by hslc_channel and hsl_to_rgb_converter_core.
`default_nettype none

package hslc_pkg;

    localparam int STAGES = 8;

    // one bit per pipeline register set, index 1 is the input stage
    typedef logic [STAGES:1] stage_vec_t;

endpackage : hslc_pkg

`default_nettype wire

>>> rtl/hslc_channel.sv
// One colour channel: hue ramp weight, ramp product, blend and scale to 8 bits.
// Occupies pipeline stages 4 to 8. Depends on hslc_pkg.
`default_nettype none

module hslc_channel
    import hslc_pkg::*;
#(
    parameter int FRAC_BITS = 15
)
(
    input  wire logic                   clk,
    input  wire stage_vec_t             load,
    input  wire logic [FRAC_BITS+1:0]   t3,
    input  wire logic [2*FRAC_BITS-1:0] sc,
    input  wire logic [3*FRAC_BITS:0]   base,
    output logic [7:0]                  chan
);

    localparam int F  = FRAC_BITS;
    localparam int TW = F + 2;
    localparam int MW = F + 1;
    localparam int PW = 2 * F + 1;
    localparam int XW = 3 * F + 1;

    localparam logic [TW:0] ONE_T   = (TW+1)'(1) << F;
    localparam logic [TW:0] TWO_T   = (TW+1)'(2) << F;
    localparam logic [TW:0] THREE_T = (TW+1)'(3) << F;
    localparam logic [TW:0] FOUR_T  = (TW+1)'(4) << F;

    logic [TW:0]   t2;
    logic [TW:0]   fall;
    logic [MW-1:0] m_next;
    logic [MW-1:0] m_reg;
    logic [PW-1:0] ph_reg;
    logic [PW-1:0] pl_reg;
    logic [XW-1:0] y_next;
    logic [XW-1:0] y_reg;
    logic [XW-1:0] x_next;
    logic [XW-1:0] x_reg;
    logic [XW+7:0] scaled;
    logic [7:0]    chan_reg;

    // weight of (q - p): rising edge, plateau, falling edge, floor
    always_comb
    begin
        t2   = {t3, 1'b0};
        fall = FOUR_T - t2;
        if (t2 < ONE_T)
        begin
            m_next = t2[MW-1:0];
        end
        else if (t2 < THREE_T)
        begin
            m_next = ONE_T[MW-1:0];
        end
        else if ({1'b0, t3} < TWO_T)
        begin
            m_next = fall[MW-1:0];
        end
        else
        begin
            m_next = '0;
        end
    end

    assign y_next = XW'({ph_reg, {F{1'b0}}}) + XW'(pl_reg);
    assign x_next = base + {y_reg[XW-2:0], 1'b0};
    assign scaled = {x_reg, 8'b0} - {8'b0, x_reg};

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            m_reg <= m_next;
        end
        if (load[5])
        begin
            ph_reg <= sc[2*F-1:F] * m_reg;
            pl_reg <= sc[F-1:0] * m_reg;
        end
        if (load[6])
        begin
            y_reg <= y_next;
        end
        if (load[7])
        begin
            x_reg <= x_next;
        end
        if (load[8])
        begin
            chan_reg <= scaled[3*F+7:3*F];
        end
    end

    assign chan = chan_reg;

endmodule : hslc_channel

`default_nettype wire

>>> rtl/hsl_to_rgb_converter_core.sv
// HSL to RGB converter, top level: input clamp, q/p terms, hue offsets, pipeline control.
// Depends on hslc_pkg and hslc_channel.
//
// Usage:
//   Input channel hsl_valid/hsl_stall carries hue, saturation and lightness,
//   unsigned fractions with 2^FRAC_BITS meaning 1.0; values above 1.0 are
//   clamped. Output channel rgb_valid/rgb_stall carries red, green, blue.
//   A transaction completes on a rising edge with valid high and stall low.
//   rgb_valid rises when a transaction reaches the last of the eight register
//   stages; one transaction per cycle is sustained while rgb_stall is low.
//   Each stage has its own valid bit and loads when empty or when the next
//   stage moves, so bubbles close up while the receiver stalls; hsl_stall
//   rises only once every stage holds a transaction. A stalled result stays
//   unchanged on the outputs.
//   Reset clears all valid bits; the pipeline is empty afterwards.
`default_nettype none

module hsl_to_rgb_converter_core
    import hslc_pkg::*;
#(
    parameter int FRAC_BITS = 15
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        hsl_valid,
    output logic             hsl_stall,
    input  wire logic [15:0] hue,
    input  wire logic [15:0] saturation,
    input  wire logic [15:0] lightness,
    output logic             rgb_valid,
    input  wire logic        rgb_stall,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue
);

    localparam int F  = FRAC_BITS;
    localparam int IW = (F + 1 > 16) ? F + 1 : 16;
    localparam int TW = F + 2;
    localparam int XW = 3 * F + 1;

    localparam logic [IW-1:0] ONE_I   = IW'(1) << F;
    localparam logic [F:0]    ONE_V   = (F+1)'(1) << F;
    localparam logic [F:0]    HALF_V  = (F+1)'(1) << (F - 1);
    localparam logic [TW:0]   ONE_T   = (TW+1)'(1) << F;
    localparam logic [TW:0]   TWO_T   = (TW+1)'(2) << F;
    localparam logic [TW:0]   THREE_T = (TW+1)'(3) << F;

    stage_vec_t valid_reg;
    stage_vec_t ready;

    logic [IW-1:0] hue_x;
    logic [IW-1:0] sat_x;
    logic [IW-1:0] lit_x;

    logic [F:0]      h1_reg, s1_reg, l1_reg;
    logic [F:0]      s2_reg, l2_reg;
    logic [F-1:0]    c2_reg;
    logic [TW-1:0]   h3_2_reg;
    logic [F:0]      c_full;
    logic [2*F:0]    sc_prod;
    logic [TW:0]     tr_sum;
    logic [TW:0]     tr_wrap;
    logic [TW:0]     tb_wrap;
    logic [2*F-1:0]  sc3_reg, sc4_reg;
    logic [F:0]      l3_reg, l4_reg;
    logic [TW-1:0]   tr3_reg, tg3_reg, tb3_reg;
    logic [XW-1:0]   base5_reg, base6_reg;

    // ready ripples back from the output register
    always_comb
    begin
        ready[STAGES] = !valid_reg[STAGES] || !rgb_stall;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[1])
            begin
                valid_reg[1] <= hsl_valid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign hsl_stall = !ready[1];
    assign rgb_valid = valid_reg[STAGES];

    // widen the inputs to IW bits for the clamp to 1.0
    assign hue_x = IW'(hue);
    assign sat_x = IW'(saturation);
    assign lit_x = IW'(lightness);

    // c = min(l, 1-l); q - p = 2sc, p = l - sc
    assign c_full  = (l1_reg < HALF_V) ? l1_reg : ONE_V - l1_reg;
    assign sc_prod = s2_reg * c2_reg;

    // hue offsets in units of 1/(3*ONE), wrapped into [0, 3]
    assign tr_sum  = {1'b0, h3_2_reg} + ONE_T;
    assign tr_wrap = (tr_sum > THREE_T) ? tr_sum - THREE_T : tr_sum;
    assign tb_wrap = ({1'b0, h3_2_reg} < ONE_T) ? {1'b0, h3_2_reg} + TWO_T
                                                : {1'b0, h3_2_reg} - ONE_T;

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            h1_reg <= (hue_x > ONE_I) ? ONE_V : hue_x[F:0];
            s1_reg <= (sat_x > ONE_I) ? ONE_V : sat_x[F:0];
            l1_reg <= (lit_x > ONE_I) ? ONE_V : lit_x[F:0];
        end
        if (ready[2])
        begin
            s2_reg   <= s1_reg;
            l2_reg   <= l1_reg;
            c2_reg   <= c_full[F-1:0];
            h3_2_reg <= TW'({h1_reg, 1'b0}) + TW'(h1_reg);
        end
        if (ready[3])
        begin
            sc3_reg <= sc_prod[2*F-1:0];
            l3_reg  <= l2_reg;
            tr3_reg <= tr_wrap[TW-1:0];
            tg3_reg <= h3_2_reg;
            tb3_reg <= tb_wrap[TW-1:0];
        end
        if (ready[4])
        begin
            sc4_reg <= sc3_reg;
            l4_reg  <= l3_reg;
        end
        if (ready[5])
        begin
            base5_reg <= {l4_reg, {(2*F){1'b0}}} - XW'({sc4_reg, {F{1'b0}}});
        end
        if (ready[6])
        begin
            base6_reg <= base5_reg;
        end
    end

    hslc_channel #(.FRAC_BITS(FRAC_BITS)) u_red
    (
        .clk  (clk),
        .load (ready),
        .t3   (tr3_reg),
        .sc   (sc4_reg),
        .base (base6_reg),
        .chan (red)
    );

    hslc_channel #(.FRAC_BITS(FRAC_BITS)) u_green
    (
        .clk  (clk),
        .load (ready),
        .t3   (tg3_reg),
        .sc   (sc4_reg),
        .base (base6_reg),
        .chan (green)
    );

    hslc_channel #(.FRAC_BITS(FRAC_BITS)) u_blue
    (
        .clk  (clk),
        .load (ready),
        .t3   (tb3_reg),
        .sc   (sc4_reg),
        .base (base6_reg),
        .chan (blue)
    );

endmodule : hsl_to_rgb_converter_core

`default_nettype wire

>>> tb/hsl_to_rgb_converter_core_tb.sv
// Self-checking testbench for hsl_to_rgb_converter_core: directed and random HSL pixels
// under varying source and sink back-pressure, checked against an exact integer colour model.
// Depends only on the RTL (hsl_to_rgb_converter_core and the packages it imports).
`default_nettype none

module hsl_to_rgb_converter_core_tb;

    localparam int FRAC_BITS = 15;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int N_RANDOM  = 1400;

    class pixel_checker;
        typedef struct packed
        {
            logic [7:0] r;
            logic [7:0] g;
            logic [7:0] b;
        } rgb_t;

        rgb_t expected_rgb[$];
        int   n_checked;
        int   n_mismatch;
        int   n_unexpected;

        function new();
            n_checked    = 0;
            n_mismatch   = 0;
            n_unexpected = 0;
        endfunction

        // x in units of 1/ONE^3, returns floor(255*x), limited to 255
        static function automatic logic [7:0] scale_byte(longint unsigned x);
            longint unsigned v;
            v = (x * 255) >> (3 * FRAC_BITS);
            return (v > 255) ? 8'd255 : v[7:0];
        endfunction

        // t3 in units of 1/(3*ONE)
        static function automatic logic [7:0] hue_ramp(longint unsigned p2, longint unsigned q2,
                                                       longint unsigned t3);
            longint unsigned one;
            longint unsigned w;
            one = ONE;
            if (2 * t3 < one)
                w = t3;
            else if (2 * t3 < 3 * one)
                return scale_byte(q2 * one);
            else if (t3 < 2 * one)
                w = 2 * one - t3;
            else
                return scale_byte(p2 * one);
            return scale_byte(p2 * one + (q2 - p2) * 2 * w);
        endfunction

        static function automatic rgb_t predict_rgb(logic [15:0] h_in, logic [15:0] s_in,
                                                    logic [15:0] l_in);
            longint unsigned one, h, s, l, q2, p2, h3, tr, tg, tb;
            rgb_t res;
            one = ONE;
            h = (h_in > one) ? one : h_in;
            s = (s_in > one) ? one : s_in;
            l = (l_in > one) ? one : l_in;
            if (s == 0)
            begin
                res.r = scale_byte(l * one * one);
                res.g = res.r;
                res.b = res.r;
                return res;
            end
            if (2 * l < one)
                q2 = l * (one + s);
            else
                q2 = l * one + s * one - l * s;
            p2 = 2 * l * one - q2;
            h3 = 3 * h;
            tr = h3 + one;
            if (tr > 3 * one)
                tr -= 3 * one;
            tg = h3;
            tb = (h3 < one) ? h3 + 2 * one : h3 - one;
            res.r = hue_ramp(p2, q2, tr);
            res.g = hue_ramp(p2, q2, tg);
            res.b = hue_ramp(p2, q2, tb);
            return res;
        endfunction

        function void note_pixel(logic [15:0] h, logic [15:0] s, logic [15:0] l);
            expected_rgb.push_back(predict_rgb(h, s, l));
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            rgb_t exp_px;
            if (expected_rgb.size() == 0)
            begin
                n_unexpected++;
                if (n_unexpected + n_mismatch <= 10)
                    $display("ERROR: unexpected result r=%0d g=%0d b=%0d", r, g, b);
                return;
            end
            exp_px = expected_rgb.pop_front();
            n_checked++;
            if (r !== exp_px.r || g !== exp_px.g || b !== exp_px.b)
            begin
                n_mismatch++;
                if (n_unexpected + n_mismatch <= 10)
                    $display("ERROR: result %0d expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                             n_checked, exp_px.r, exp_px.g, exp_px.b, r, g, b);
            end
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        hsl_valid;
    logic        hsl_stall;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;
    logic        rgb_valid;
    logic        rgb_stall;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    pixel_checker sb;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           n_sent;

    hsl_to_rgb_converter_core #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsl_valid (hsl_valid),
        .hsl_stall (hsl_stall),
        .hue       (hue),
        .saturation(saturation),
        .lightness (lightness),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // sink: check completed transactions, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n && rgb_valid && !rgb_stall)
            sb.check_pixel(red, green, blue);
        rgb_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_pixel(input logic [15:0] h, input logic [15:0] s, input logic [15:0] l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hsl_valid <= 1'b0;
            @(posedge clk);
        end
        hsl_valid  <= 1'b1;
        hue        <= h;
        saturation <= s;
        lightness  <= l;
        @(posedge clk);
        while (hsl_stall)
            @(posedge clk);
        sb.note_pixel(h, s, l);
        n_sent++;
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(7))
            0:       return 16'(0);
            1:       return 16'(ONE);
            2:       return 16'($urandom_range(65535));
            3:       return 16'(ONE + 1 + $urandom_range(65535 - ONE - 1));
            4:       return 16'($urandom_range(ONE / 2 - 2, ONE / 2 + 2));
            default: return 16'($urandom_range(ONE));
        endcase
    endfunction

    // hue near a ramp break point (multiples of one sixth)
    function automatic logic [15:0] pick_hue_edge();
        int k;
        int base;
        k    = $urandom_range(6);
        base = (k * ONE) / 6;
        return 16'($urandom_range((base > 3) ? base - 3 : 0, (base + 3 > ONE) ? ONE : base + 3));
    endfunction

    task automatic send_random_pixel();
        logic [15:0] h, s, l;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                h = 16'($urandom_range(ONE));
                s = 16'($urandom_range(ONE));
                l = 16'($urandom_range(ONE));
            end
            4:
            begin
                h = 16'($urandom_range(65535));
                s = 16'($urandom_range(65535));
                l = 16'($urandom_range(65535));
            end
            5:
            begin
                h = 16'($urandom_range(65535));
                s = 16'd0;
                l = pick_level();
            end
            6, 7:
            begin
                h = pick_hue_edge();
                s = pick_level();
                l = pick_level();
            end
            default:
            begin
                h = pick_level();
                s = pick_level();
                l = pick_level();
            end
        endcase
        send_pixel(h, s, l);
    endtask

    initial
    begin
        sb            = new();
        n_sent        = 0;
        send_idle_pct = 36;
        recv_idle_pct = 63;
        rst_n         = 1'b0;
        hsl_valid     = 1'b0;
        hue           = '0;
        saturation    = '0;
        lightness     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, grey, clamping, hue of one, ramp break points
        send_pixel(16'd0,      16'd0,      16'd0);
        send_pixel(16'd0,      16'd0,      16'(ONE));
        send_pixel(16'd0,      16'd0,      16'd16384);
        send_pixel(16'd12345,  16'd0,      16'd65535);
        send_pixel(16'd0,      16'(ONE),   16'd16384);
        send_pixel(16'(ONE),   16'(ONE),   16'd16384);
        send_pixel(16'd65535,  16'(ONE),   16'd16384);
        send_pixel(16'd10923,  16'(ONE),   16'd16384);
        send_pixel(16'd21845,  16'(ONE),   16'd16384);
        send_pixel(16'd5461,   16'd65535,  16'd16384);
        send_pixel(16'd5462,   16'(ONE),   16'd16383);
        send_pixel(16'd16384,  16'(ONE),   16'd16385);
        send_pixel(16'd27306,  16'd20000,  16'd8000);
        send_pixel(16'd27307,  16'd20000,  16'd30000);
        send_pixel(16'd32767,  16'd1,      16'd1);
        send_pixel(16'd1,      16'd32767,  16'd32767);
        send_pixel(16'd65535,  16'd65535,  16'd65535);
        send_pixel(16'd32769,  16'd32769,  16'd32769);
        send_pixel(16'd7000,   16'(ONE),   16'(ONE));
        send_pixel(16'd7000,   16'(ONE),   16'd0);
        send_pixel(16'hAAAA,   16'h5555,   16'h5555);
        send_pixel(16'h5555,   16'hAAAA,   16'h2AAA);

        for (int i = 0; i < N_RANDOM / 3; i++)
            send_random_pixel();
        send_idle_pct = 63;
        recv_idle_pct = 36;
        for (int i = 0; i < N_RANDOM / 3; i++)
            send_random_pixel();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < N_RANDOM - 2 * (N_RANDOM / 3); i++)
            send_random_pixel();
        hsl_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Converted %0d pixels (directed edges, clamped inputs, grey, hue break points),",
                 n_sent);
        $display("%0d results checked across three back-pressure phases, %0d errors",
                 sb.n_checked, sb.n_mismatch + sb.n_unexpected);
        if (sb.n_mismatch == 0 && sb.n_unexpected == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(200000 * 8);
        $display("ERROR: timeout with %0d results outstanding", sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> hsl_to_rgb_converter_core.f
rtl/hslc_pkg.sv
rtl/hslc_channel.sv
rtl/hsl_to_rgb_converter_core.sv
tb/hsl_to_rgb_converter_core_tb.sv
